### hw/rtl/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types and constants for the DMA request multiplexer.
// ----------------------------------------------------------------------------
package dmx_pkg;

   localparam int CHANNELS_DEFAULT     = 16;
   localparam int WINDOW_BYTES_DEFAULT = 256;

   localparam int OFFSET_XOR    = 3;
   localparam int INSTANCE_BASE = 16;

   localparam logic [1:0] ACT_READ    = 2'd0;
   localparam logic [1:0] ACT_WRITE   = 2'd1;
   localparam logic [1:0] ACT_REQUEST = 2'd2;

   localparam logic RK_READ    = 1'b0;
   localparam logic RK_TRIGGER = 1'b1;

   localparam int ENABLE_POS = 7;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  byte_offset;
      logic [2:0]  access_bytes;
      logic [31:0] write_data;
      logic [5:0]  request_source;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] read_data;
      logic        access_error;
      logic [4:0]  trig_channel;
      logic        last;
   } rsp_type;

   // Broadcast from the sequencer to every channel cell
   typedef struct packed {
      logic        write;
      logic [7:0]  byte_offset;
      logic [2:0]  access_bytes;
      logic [31:0] write_data;
      logic [5:0]  source;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

### hw/rtl/dma_request_mux_router.sv
// ----------------------------------------------------------------------------
// dma_request_mux_router
// DMA request multiplexer: per-channel enable/source bytes, bus access to
// them and fan-out of peripheral requests to matching DMA channels.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words are taken at a clock edge with start high and busy low.
//    action selects a register read, a register write or a request event.
//  - Results come out on rsp for one cycle each, marked by rsp_strobe; the
//    receiver must take them as they come.
//  - A read gives one result in the cycle after acceptance and leaves busy
//    low. A write updates the channel bytes at the accepting edge, gives no
//    result and leaves busy low.
//  - A request sends a token down the row of channel cells, one cell per
//    cycle. busy stays high through ST_SCAN and ST_FLUSH; each match is held one
//    step so the final one can carry last. The trigger results are issued
//    from ST_SCAN and ST_FLUSH and registered onto rsp.
//  - csr_wdata sets the instance bit; the port is always ready. The user must
//    write it only while the block is idle; the block does not enforce this.
//  - Synchronous reset clears every channel byte (all disabled), the
//    instance bit and the sequencer.
// ----------------------------------------------------------------------------
module dma_request_mux_router #(
   parameter int CHANNELS     = dmx_pkg::CHANNELS_DEFAULT,
   parameter int WINDOW_BYTES = dmx_pkg::WINDOW_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dmx_pkg::req_type req,
   output logic             rsp_strobe,
   output dmx_pkg::rsp_type rsp,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);
   import dmx_pkg::*;

   localparam int CW = $clog2(CHANNELS);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           pend_valid_ff, pend_valid_in;
   logic [CW-1:0]  pend_ch_ff, pend_ch_in;
   logic [5:0]     src_ff, src_in;
   logic           instance_ff, instance_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_ff, rsp_in;

   cell_ctl_type   ctl;
   logic           accept;
   logic           bad;
   logic           start_scan;
   logic           any_hit;
   logic [31:0]    read_word;
   logic [CHANNELS-1:0]      token;
   logic [CHANNELS-1:0]      hit;
   logic [CHANNELS-1:0][31:0] read_lane;

   genvar gi;
   generate
      for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
         dmx_cell #(
            .INDEX    (gi),
            .CHANNELS (CHANNELS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .token_in  ((gi == 0) ? start_scan : token[(gi == 0) ? 0 : gi - 1]),
            .token_out (token[gi]),
            .hit       (hit[gi]),
            .read_lane (read_lane[gi])
         );
      end
   endgenerate

   always_comb begin
      accept = start && !busy;
      bad    = (req.access_bytes > 3'd4) ||
               (({5'b0, req.byte_offset} + {10'b0, req.access_bytes}) >
                13'(WINDOW_BYTES));

      ctl.write        = accept && (req.action == ACT_WRITE) && !bad;
      ctl.byte_offset  = req.byte_offset;
      ctl.access_bytes = req.access_bytes;
      ctl.write_data   = req.write_data;
      ctl.source       = src_ff;

      read_word = 32'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         read_word = read_word | read_lane[i];
      end
      any_hit = |hit;
   end

   // Sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      src_in        = src_ff;
      start_scan    = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      instance_in   = (csr_valid && csr_ready) ? csr_wdata : instance_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.action == ACT_READ)) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.result_kind  = RK_READ;
               rsp_in.read_data    = bad ? 32'b0 : read_word;
               rsp_in.access_error = bad;
               rsp_in.trig_channel = 5'b0;
               rsp_in.last         = 1'b1;
            end else if (accept && (req.action == ACT_REQUEST)) begin
               start_scan    = 1'b1;
               src_in        = req.request_source;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               // Release the held match now that a later one exists
               if (pend_valid_ff) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.result_kind  = RK_TRIGGER;
                  rsp_in.read_data    = 32'b0;
                  rsp_in.access_error = 1'b0;
                  rsp_in.trig_channel = 5'(pend_ch_ff) |
                                        (instance_ff ? 5'(INSTANCE_BASE) : 5'b0);
                  rsp_in.last         = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_ch_in    = cnt_ff;
            end
            if (cnt_ff == CW'(CHANNELS - 1)) begin
               state_in = ST_FLUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in       = 1'b1;
               rsp_in.result_kind  = RK_TRIGGER;
               rsp_in.read_data    = 32'b0;
               rsp_in.access_error = 1'b0;
               rsp_in.trig_channel = 5'(pend_ch_ff) |
                                     (instance_ff ? 5'(INSTANCE_BASE) : 5'b0);
               rsp_in.last         = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         instance_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         instance_ff   <= instance_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ch_ff <= pend_ch_in;
      src_ff     <= src_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

### hw/rtl/dmx_cell.sv
// ----------------------------------------------------------------------------
// dmx_cell
// One mux channel: holds its configuration byte, serves bus lanes that map
// to it and passes the scan token to the next channel.
// ----------------------------------------------------------------------------
module dmx_cell #(
   parameter int INDEX    = 0,
   parameter int CHANNELS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dmx_pkg::cell_ctl_type ctl,
   input  logic                 token_in,
   output logic                 token_out,
   output logic                 hit,
   output logic [31:0]          read_lane
);
   import dmx_pkg::*;

   localparam logic [7:0] LaneOff = 8'(INDEX ^ OFFSET_XOR);
   localparam bit         Mapped  = (INDEX ^ OFFSET_XOR) < CHANNELS;

   logic [7:0] cfg_ff;
   logic [7:0] cfg_in;
   logic       token_ff;
   logic [7:0] lane_dist;
   logic [1:0] lane;
   logic       in_lane;
   logic       match;

   always_comb begin
      lane_dist = LaneOff - ctl.byte_offset;
      lane      = lane_dist[1:0];
      in_lane   = Mapped && (ctl.byte_offset <= LaneOff) &&
                  (lane_dist < {5'b0, ctl.access_bytes});
      cfg_in    = cfg_ff;
      if (ctl.write && in_lane) begin
         cfg_in = ctl.write_data[{lane, 3'b000} +: 8];
      end
      match     = cfg_ff[ENABLE_POS] && (cfg_ff[5:0] == ctl.source);
      read_lane = in_lane ? ({24'b0, cfg_ff} << {lane, 3'b000}) : 32'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= 8'b0;
         token_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         token_ff <= token_in;
      end
   end

   assign token_out = token_ff;
   assign hit       = token_ff & match;

endmodule

### sim/dma_request_mux_router_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_request_mux_router_tb
// Drives register reads, writes and peripheral requests into the DMA request
// multiplexer in random bursts. A model of the channel bytes and the instance
// bit predicts every read word and every trigger word, and each word on rsp
// is compared against the oldest one predicted.
// ----------------------------------------------------------------------------
module dma_request_mux_router_tb;
   import dmx_pkg::*;

   localparam int CHANNELS     = 16;
   localparam int WINDOW_BYTES = 256;
   localparam int SETTLE       = CHANNELS + 4;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 81;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_wdata;

   dma_request_mux_router #(
      .CHANNELS     (CHANNELS),
      .WINDOW_BYTES (WINDOW_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   class mux_scoreboard;
      logic [7:0] chan_bytes [CHANNELS];
      logic       inst_hi;
      rsp_type    pending_words [$];
      int         errors;

      function new();
         foreach (chan_bytes[i]) chan_bytes[i] = 8'h00;
         inst_hi = 1'b0;
         errors  = 0;
      endfunction

      function void set_instance(logic v);
         inst_hi = v;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function bit lane_to_chan(int addr, output int ch);
         ch = addr ^ OFFSET_XOR;
         return (addr < CHANNELS) && (ch < CHANNELS);
      endfunction

      // Predict the words caused by one accepted input word
      function void take_word(req_type r);
         int         off;
         int         nb;
         int         ch;
         bit         bad;
         bit         have;
         logic [31:0] data;
         rsp_type    w;
         rsp_type    held;
         off  = r.byte_offset;
         nb   = r.access_bytes;
         bad  = (nb > 4) || (off + nb > WINDOW_BYTES);
         have = 1'b0;
         w    = '0;
         held = '0;
         case (r.action)
            ACT_READ: begin
               data = '0;
               if (!bad) begin
                  for (int i = 0; i < nb; i++) begin
                     if (lane_to_chan(off + i, ch)) data |= 32'(chan_bytes[ch]) << (8 * i);
                  end
               end
               w.result_kind  = RK_READ;
               w.read_data    = data;
               w.access_error = bad;
               w.trig_channel = '0;
               w.last         = 1'b1;
               pending_words.push_back(w);
            end
            ACT_WRITE: begin
               if (!bad) begin
                  for (int i = 0; i < nb; i++) begin
                     if (lane_to_chan(off + i, ch)) chan_bytes[ch] = r.write_data[8*i +: 8];
                  end
               end
            end
            ACT_REQUEST: begin
               // hold each match one step so the final one can carry last
               for (int c = 0; c < CHANNELS; c++) begin
                  if (chan_bytes[c][ENABLE_POS] && chan_bytes[c][5:0] == r.request_source) begin
                     if (have) pending_words.push_back(held);
                     held              = '0;
                     held.result_kind  = RK_TRIGGER;
                     held.trig_channel = 5'(c + (inst_hi ? INSTANCE_BASE : 0));
                     have              = 1'b1;
                  end
               end
               if (have) begin
                  held.last = 1'b1;
                  pending_words.push_back(held);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: kind=%0d data=%h err=%0d ch=%0d last=%0d",
                        got.result_kind, got.read_data, got.access_error,
                        got.trig_channel, got.last);
            return;
         end
         exp = pending_words.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) begin
               $write("mismatch: expected kind=%0d data=%h err=%0d ch=%0d last=%0d,",
                      exp.result_kind, exp.read_data, exp.access_error,
                      exp.trig_channel, exp.last);
               $display(" got kind=%0d data=%h err=%0d ch=%0d last=%0d",
                        got.result_kind, got.read_data, got.access_error,
                        got.trig_channel, got.last);
            end
         end
      endfunction
   endclass

   mux_scoreboard sb;
   int            stall_cycles;
   int            burst_left;
   int            source_pool [3];
   int            phase_inst [5] = '{1, 0, 1, 0, 1};

   always #2 clock = ~clock;

   // Observe the result, CSR and input channels at each edge: results first, then the instance bit, then the new word
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_strobe) sb.check_word(rsp);
         if (csr_valid && csr_ready) sb.set_instance(csr_wdata);
         if (start && !busy) sb.take_word(req);
         if (rsp_strobe || (csr_valid && csr_ready) || (start && !busy))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type mk(logic [1:0] action, int off, int nb,
                                  logic [31:0] data, int src);
      req_type r;
      r.action         = action;
      r.byte_offset    = 8'(off);
      r.access_bytes   = 3'(nb);
      r.write_data     = data;
      r.request_source = 6'(src);
      return r;
   endfunction

   // Channel byte with a source from the current pool, mostly enabled
   function automatic logic [7:0] cfg_byte();
      logic en;
      en = ($urandom_range(0, 9) != 0);
      return {en, 1'($urandom_range(0, 1)), 6'(source_pool[$urandom_range(0, 2)])};
   endfunction

   function automatic req_type rand_item();
      int pick;
      int src;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) src = $urandom_range(0, 63);
      else src = source_pool[$urandom_range(0, 2)];
      if (pick < 30)
         return mk(ACT_WRITE, $urandom_range(0, 15), $urandom_range(1, 4),
                   {cfg_byte(), cfg_byte(), cfg_byte(), cfg_byte()}, $urandom_range(0, 63));
      if (pick < 60)
         return mk(ACT_REQUEST, $urandom_range(0, 255), $urandom_range(0, 7), $urandom, src);
      if (pick < 80)
         return mk(ACT_READ, $urandom_range(0, 19), $urandom_range(1, 4), $urandom,
                   $urandom_range(0, 63));
      return mk(2'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 7),
                $urandom, $urandom_range(0, 63));
   endfunction

   // Called right after an edge; returns at the edge that accepts the word
   task automatic send_word(req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      start <= 1'b1;
      req   <= item;
      do @(posedge clock); while (busy);
      burst_left--;
   endtask

   // Drain, let a no-result word finish, then set the instance bit
   task automatic write_instance(logic v);
      start <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req        = '0;
      csr_valid  = 1'b0;
      csr_wdata  = 1'b0;
      burst_left = 0;
      sb         = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words, instance bit at its reset value
      send_word(mk(ACT_READ,    0,   4, 32'h0,        0));
      send_word(mk(ACT_REQUEST, 0,   1, 32'h0,        0));
      send_word(mk(ACT_WRITE,   0,   4, 32'h80BFC0FF, 0));
      send_word(mk(ACT_READ,    0,   4, 32'h0,        0));
      send_word(mk(ACT_REQUEST, 0,   1, 32'h0,        63));
      send_word(mk(ACT_REQUEST, 0,   1, 32'h0,        0));
      send_word(mk(ACT_WRITE,   4,   4, 32'hFFFFFFFF, 0));
      send_word(mk(ACT_WRITE,   8,   4, 32'hFFFFFFFF, 0));
      send_word(mk(ACT_WRITE,   12,  4, 32'hFFFFFFFF, 0));
      send_word(mk(ACT_WRITE,   0,   4, 32'hFFFFFFFF, 0));
      send_word(mk(ACT_REQUEST, 255, 7, 32'hFFFFFFFF, 63));
      send_word(mk(ACT_WRITE,   15,  1, 32'h00000000, 0));
      send_word(mk(ACT_WRITE,   14,  2, 32'h00003F05, 0));
      send_word(mk(ACT_READ,    13,  4, 32'h0,        0));
      send_word(mk(ACT_WRITE,   16,  4, 32'h12345678, 0));
      send_word(mk(ACT_WRITE,   253, 4, 32'h0,        0));
      send_word(mk(ACT_READ,    252, 4, 32'h0,        0));
      send_word(mk(ACT_READ,    253, 4, 32'h0,        0));
      send_word(mk(ACT_READ,    255, 1, 32'h0,        0));
      send_word(mk(ACT_READ,    255, 2, 32'h0,        0));
      send_word(mk(ACT_READ,    0,   0, 32'h0,        0));
      send_word(mk(ACT_WRITE,   0,   0, 32'h0,        0));
      send_word(mk(ACT_READ,    0,   5, 32'h0,        0));
      send_word(mk(ACT_WRITE,   0,   7, 32'h0,        0));
      send_word(mk(2'd3,        0,   4, 32'h0,        63));
      send_word(mk(ACT_REQUEST, 0,   1, 32'h0,        63));

      foreach (phase_inst[p]) begin
         write_instance(phase_inst[p][0]);
         foreach (source_pool[k]) source_pool[k] = $urandom_range(0, 63);
         repeat (PHASE_ITEMS) send_word(rand_item());
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
